// ===== src/wrr_pkg.sv =====
// ============================================================================
// wrr_pkg
// Shared types, widths and codes for the weighted round-robin run queue.
// ============================================================================
package wrr_pkg;

    localparam int TASK_W        = 6;
    localparam int CMD_W         = 3;
    localparam int UID_W         = 32;
    localparam int WEIGHT_W      = 8;
    localparam int TICKS_W       = 10;
    localparam int FULL_W        = WEIGHT_W + TICKS_W;   // weight * slice_ticks
    localparam int SLICE_W       = FULL_W + 1;           // signed slice counter
    localparam int COUNT_OUT_W   = 7;
    localparam int WSUM_W        = 14;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int IN_TDATA_W    = 48;
    localparam int OUT_TDATA_W   = 32;

    localparam int DEF_MAX_TASKS = 64;

    localparam logic [WSUM_W-1:0]   WSUM_MAX    = '1;
    localparam logic [WEIGHT_W-1:0] BASE_WEIGHT = 8'd1;

    localparam logic [WEIGHT_W-1:0]   RST_BOOST_WT       = 8'd10;
    localparam logic [TICKS_W-1:0]    RST_SLICE_TICKS    = 10'd10;
    localparam logic [UID_W-1:0]      RST_USER_THRESHOLD = 32'd10000;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE = 3'd0,
        CMD_DEQUEUE = 3'd1,
        CMD_TICK    = 3'd2,
        CMD_YIELD   = 3'd3,
        CMD_SET_CUR = 3'd4
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOOST_WT           = 2'd0,
        CFG_SLICE_TICKS        = 2'd1,
        CFG_APP_USER_THRESHOLD = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TMOD,
        ST_TICK,
        ST_WALK,
        ST_TAIL,
        ST_HEAD,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] boost_wt;
        logic [TICKS_W-1:0]  slice_ticks;
        logic [UID_W-1:0]    app_user_threshold;
    } cfg_t;

    typedef struct packed {
        logic [WSUM_W-1:0]      weight_sum;
        logic [COUNT_OUT_W-1:0] running_count;
        logic                   resched;
        logic                   queue_empty;
        logic [TASK_W-1:0]      head_task;
    } result_t;

    typedef struct packed {
        logic                in_queue;
        logic [WEIGHT_W-1:0] weight;
        logic [SLICE_W-1:0]  slice;
    } task_entry_t;

endpackage

// ===== src/weighted_round_robin_run_queue.sv =====
// ============================================================================
// weighted_round_robin_run_queue
// FIFO run queue of task slots with per-task weight and time slice.
// ============================================================================
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------
//  s_       | in  | s_tvalid/s_tready  | s_tdata: command, task_id, user_id
//  m_       | out | m_tvalid/m_tready  | m_tdata: head, empty, resched, count, sum
//  cfg_     | in  | cfg_wr_en          | cfg_index, cfg_wdata
//
//  Enqueue, yield and set current pass TMOD, HEAD and OUT; an unknown command
//  or out-of-range task skips TMOD, a tick adds TICK. Dequeue of a queued task
//  and a rotating tick walk the queue memory one entry per cycle in WALK, the
//  rotation then appends at the tail. A clearing pass after reset zeroes the
//  task table with s_tready low. The result sits in an output register, so a
//  stalled m_ side only holds the block once a second result is ready.
// ============================================================================
module weighted_round_robin_run_queue #(
    parameter int MAX_TASKS = wrr_pkg::DEF_MAX_TASKS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [2:0] command, [8:3] task_id, [40:9] user_id, rest zero
    input  logic [wrr_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [5:0] head_task, [6] queue_empty, [7] resched, [14:8] running_count,
    // [28:15] weight_sum, rest zero
    output logic [wrr_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [wrr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wrr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import wrr_pkg::*;

    localparam int AW = $clog2(MAX_TASKS);

    cfg_t                  cfg_reg;
    logic                  m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    logic                  res_valid;
    logic                  res_ready;
    result_t               res;

    logic                  q_we;
    logic [AW-1:0]         q_waddr;
    logic [TASK_W-1:0]     q_wdata;
    logic [AW-1:0]         q_raddr;
    logic [TASK_W-1:0]     q_rdata;
    logic                  t_we;
    logic [AW-1:0]         t_waddr;
    task_entry_t           t_wdata;
    logic [AW-1:0]         t_raddr;
    task_entry_t           t_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.boost_wt           <= RST_BOOST_WT;
            cfg_reg.slice_ticks        <= RST_SLICE_TICKS;
            cfg_reg.app_user_threshold <= RST_USER_THRESHOLD;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_BOOST_WT: begin
                    cfg_reg.boost_wt <= cfg_wdata[WEIGHT_W-1:0];
                end
                CFG_SLICE_TICKS: begin
                    cfg_reg.slice_ticks <= cfg_wdata[TICKS_W-1:0];
                end
                CFG_APP_USER_THRESHOLD: begin
                    cfg_reg.app_user_threshold <= cfg_wdata[UID_W-1:0];
                end
                default: ;
            endcase
        end
    end

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= OUT_TDATA_W'({res.weight_sum, res.running_count,
                                         res.resched, res.queue_empty,
                                         res.head_task});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    wrr_ram #(
        .WIDTH (TASK_W),
        .DEPTH (MAX_TASKS)
    ) u_queue_ram (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    wrr_ram #(
        .WIDTH ($bits(task_entry_t)),
        .DEPTH (MAX_TASKS)
    ) u_task_ram (
        .aclk  (aclk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    wrr_ctrl #(
        .MAX_TASKS (MAX_TASKS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tdata[CMD_W-1:0]),
        .in_task   (s_tdata[CMD_W +: TASK_W]),
        .in_user   (s_tdata[CMD_W + TASK_W +: UID_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .q_we      (q_we),
        .q_waddr   (q_waddr),
        .q_wdata   (q_wdata),
        .q_raddr   (q_raddr),
        .q_rdata   (q_rdata),
        .t_we      (t_we),
        .t_waddr   (t_waddr),
        .t_wdata   (t_wdata),
        .t_raddr   (t_raddr),
        .t_rdata   (t_rdata)
    );

endmodule

// ===== src/wrr_ram.sv =====
// ============================================================================
// wrr_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module wrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/wrr_ctrl.sv =====
// ============================================================================
// wrr_ctrl
// Command sequencer: read-modify-write of task state and queue walks.
// ============================================================================
module wrr_ctrl #(
    parameter int MAX_TASKS = wrr_pkg::DEF_MAX_TASKS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  wrr_pkg::cfg_t                       cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [wrr_pkg::CMD_W-1:0]           in_cmd,
    input  logic [wrr_pkg::TASK_W-1:0]          in_task,
    input  logic [wrr_pkg::UID_W-1:0]           in_user,
    output logic                                res_valid,
    input  logic                                res_ready,
    output wrr_pkg::result_t                    res,
    output logic                                q_we,
    output logic [$clog2(MAX_TASKS)-1:0]        q_waddr,
    output logic [wrr_pkg::TASK_W-1:0]          q_wdata,
    output logic [$clog2(MAX_TASKS)-1:0]        q_raddr,
    input  logic [wrr_pkg::TASK_W-1:0]          q_rdata,
    output logic                                t_we,
    output logic [$clog2(MAX_TASKS)-1:0]        t_waddr,
    output wrr_pkg::task_entry_t                t_wdata,
    output logic [$clog2(MAX_TASKS)-1:0]        t_raddr,
    input  wrr_pkg::task_entry_t                t_rdata
);
    import wrr_pkg::*;

    localparam int AW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    ctrl_state_t          state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [TASK_W-1:0]    tid_reg, tid_next;
    logic [UID_W-1:0]     uid_reg, uid_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [WSUM_W-1:0]    wsum_reg, wsum_next;
    logic [CW-1:0]        walk_reg, walk_next;
    logic                 found_reg, found_next;
    logic                 rot_reg, rot_next;
    logic [AW-1:0]        clr_reg, clr_next;
    logic [WEIGHT_W-1:0]  w0_reg, w0_next;
    logic [SLICE_W-1:0]   slice_reg, slice_next;
    logic [FULL_W-1:0]    full_reg, full_next;
    logic                 inq_reg, inq_next;

    logic                 in_accept;
    logic                 in_range;
    logic                 hit;
    logic [SLICE_W-1:0]   dec;
    logic                 expired;
    logic                 heavy;
    logic [WEIGHT_W-1:0]  w_fix;
    logic [WEIGHT_W-1:0]  w_set;
    logic [WSUM_W:0]      wsum_sum;

    function automatic logic [WSUM_W-1:0] wsum_sub(input logic [WSUM_W-1:0] a,
                                                   input logic [WEIGHT_W-1:0] b);
        logic [WSUM_W-1:0] bx;
        bx = WSUM_W'(b);
        return (a > bx) ? a - bx : '0;
    endfunction

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign in_range  = (32'(in_task) < 32'(MAX_TASKS));

    // walk: data of entry walk-1 is on q_rdata
    assign hit      = (walk_reg != '0) && !found_reg && (q_rdata == tid_reg);
    assign dec      = slice_reg - SLICE_W'(1);
    assign expired  = ($signed(dec) <= $signed(SLICE_W'(0))) ||
                      ($signed(dec) > $signed({1'b0, full_reg}));
    assign heavy    = (w0_reg > BASE_WEIGHT);
    assign w_fix    = (t_rdata.weight == '0) ? BASE_WEIGHT : t_rdata.weight;
    assign w_set    = (uid_reg >= cfg.app_user_threshold) ? cfg.boost_wt
                                                           : BASE_WEIGHT;
    assign wsum_sum = {1'b0, wsum_reg} + (WSUM_W + 1)'(t_rdata.weight);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
            wsum_reg  <= '0;
            walk_reg  <= '0;
            found_reg <= 1'b0;
            rot_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
            wsum_reg  <= wsum_next;
            walk_reg  <= walk_next;
            found_reg <= found_next;
            rot_reg   <= rot_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        tid_reg   <= tid_next;
        uid_reg   <= uid_next;
        w0_reg    <= w0_next;
        slice_reg <= slice_next;
        full_reg  <= full_next;
        inq_reg   <= inq_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        tid_next   = tid_reg;
        uid_next   = uid_reg;
        count_next = count_reg;
        wsum_next  = wsum_reg;
        walk_next  = walk_reg;
        found_next = found_reg;
        rot_next   = rot_reg;
        clr_next   = clr_reg;
        w0_next    = w0_reg;
        slice_next = slice_reg;
        full_next  = full_reg;
        inq_next   = inq_reg;

        q_we      = 1'b0;
        q_waddr   = AW'(count_reg);
        q_wdata   = tid_reg;
        q_raddr   = '0;
        t_we      = 1'b0;
        t_waddr   = AW'(tid_reg);
        t_wdata   = t_rdata;
        t_raddr   = AW'(tid_reg);
        res_valid = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                t_we     = 1'b1;
                t_waddr  = clr_reg;
                t_wdata  = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(MAX_TASKS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                t_raddr = AW'(in_task);
                if (in_accept) begin
                    cmd_next = cmd_t'(in_cmd);
                    tid_next = in_task;
                    uid_next = in_user;
                    rot_next = 1'b0;
                    if (in_range && in_cmd <= CMD_SET_CUR) begin
                        state_next = ST_TMOD;
                    end else begin
                        state_next = ST_HEAD;
                    end
                end
            end
            ST_TMOD: begin
                state_next = ST_HEAD;
                unique case (cmd_reg)
                    CMD_ENQUEUE: begin
                        if (!t_rdata.in_queue && count_reg < CW'(MAX_TASKS)) begin
                            q_we             = 1'b1;
                            count_next       = count_reg + CW'(1);
                            wsum_next        = (wsum_sum > {1'b0, WSUM_MAX}) ?
                                               WSUM_MAX : wsum_sum[WSUM_W-1:0];
                            t_we             = 1'b1;
                            t_wdata.in_queue = 1'b1;
                        end
                    end
                    CMD_DEQUEUE: begin
                        if (t_rdata.in_queue) begin
                            wsum_next        = wsum_sub(wsum_reg, t_rdata.weight);
                            t_we             = 1'b1;
                            t_wdata.in_queue = 1'b0;
                            walk_next        = '0;
                            found_next       = 1'b0;
                            state_next       = ST_WALK;
                        end
                    end
                    CMD_TICK: begin
                        w0_next    = w_fix;
                        slice_next = t_rdata.slice;
                        inq_next   = t_rdata.in_queue;
                        full_next  = FULL_W'(w_fix) * FULL_W'(cfg.slice_ticks);
                        state_next = ST_TICK;
                    end
                    CMD_YIELD: begin
                        t_we          = 1'b1;
                        t_wdata.slice = '0;
                    end
                    CMD_SET_CUR: begin
                        t_we           = 1'b1;
                        t_wdata.weight = w_set;
                        t_wdata.slice  = SLICE_W'(FULL_W'(w_set) *
                                                  FULL_W'(cfg.slice_ticks));
                    end
                    default: ;
                endcase
            end
            ST_TICK: begin
                t_we             = 1'b1;
                t_wdata.in_queue = inq_reg;
                state_next       = ST_HEAD;
                if (!expired) begin
                    t_wdata.weight = w0_reg;
                    t_wdata.slice  = dec;
                end else begin
                    // refill: a heavy task decays, (w-1)*ticks = full - ticks; else full
                    if (heavy) begin
                        t_wdata.weight = w0_reg - WEIGHT_W'(1);
                        t_wdata.slice  = {1'b0, full_reg - FULL_W'(cfg.slice_ticks)};
                        wsum_next      = wsum_sub(wsum_reg, BASE_WEIGHT);
                    end else begin
                        t_wdata.weight = w0_reg;
                        t_wdata.slice  = {1'b0, full_reg};
                    end
                    if (inq_reg && count_reg > CW'(1)) begin
                        rot_next   = 1'b1;
                        walk_next  = '0;
                        found_next = 1'b0;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                // one pass: find the task, shift every later entry down by one
                q_raddr = walk_reg[AW-1:0];
                q_wdata = q_rdata;
                q_waddr = AW'(walk_reg - CW'(2));
                if (walk_reg != '0 && found_reg) begin
                    q_we = 1'b1;
                end
                if (hit) begin
                    found_next = 1'b1;
                end
                if (walk_reg == count_reg) begin
                    count_next = count_reg - CW'(1);
                    state_next = rot_reg ? ST_TAIL : ST_HEAD;
                end else begin
                    walk_next = walk_reg + CW'(1);
                end
            end
            ST_TAIL: begin
                q_we       = 1'b1;
                q_waddr    = AW'(count_reg);
                q_wdata    = tid_reg;
                count_next = count_reg + CW'(1);
                state_next = ST_HEAD;
            end
            ST_HEAD: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        res.head_task     = (count_reg == '0) ? '0 : q_rdata;
        res.queue_empty   = (count_reg == '0);
        res.resched       = rot_reg;
        res.running_count = COUNT_OUT_W'(count_reg);
        res.weight_sum    = wsum_reg;
    end

    // queue never holds more than the slot count
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_TASKS))
        else $error("run queue count above capacity");

    // count moves by at most one per cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (count_reg == $past(count_reg) ||
                            count_reg == $past(count_reg) + CW'(1) ||
                            count_reg + CW'(1) == $past(count_reg)))
        else $error("run queue count jumped");

    // a walk only starts for a queued task, so it must find it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK && walk_reg == count_reg) |-> (found_reg || hit))
        else $error("queue walk did not find the task");

    // task state is written only by the clear pass and the update states
    assert property (@(posedge aclk) disable iff (!aresetn)
        t_we |-> (state_reg == ST_CLEAR || state_reg == ST_TMOD ||
                  state_reg == ST_TICK))
        else $error("unexpected task state write");

endmodule

// ===== tb/testbench.sv =====
// ============================================================================
// testbench
// Self-checking bench for the weighted round-robin run queue. Commands go in
// on the s_ stream in random bursts, status words come back on the m_ stream
// under random back-pressure. A software run queue predicts every status word,
// and each returned word is compared field by field in order of arrival.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wrr_pkg::*;

    localparam logic [CMD_W-1:0] CMD_CODE_MAX = '1;      // codes above set current are unused
    localparam int               MAX_REPORTS  = 40;
    localparam int               DRAIN_CYCLES = DEF_MAX_TASKS + 16;
    localparam int               LIMIT_NS     = 5_000_000;

    // Software copy of the run queue; predicts one status word per command.
    class run_queue_tracker;
        logic [WEIGHT_W-1:0] boost_weight;
        logic [TICKS_W-1:0]  ticks_per_weight;
        logic [UID_W-1:0]    boost_threshold;
        int unsigned         run_order[$];
        int unsigned         weight[DEF_MAX_TASKS];
        int                  slice_left[DEF_MAX_TASKS];
        int unsigned         weight_total;
        result_t             status_q[$];
        int unsigned         n_errors;

        function new();
            boost_weight     = RST_BOOST_WT;
            ticks_per_weight = RST_SLICE_TICKS;
            boost_threshold  = RST_USER_THRESHOLD;
            foreach (weight[i]) begin
                weight[i]     = 0;
                slice_left[i] = 0;
            end
            weight_total = 0;
            n_errors     = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_BOOST_WT:           boost_weight     = value[WEIGHT_W-1:0];
                CFG_SLICE_TICKS:        ticks_per_weight = value[TICKS_W-1:0];
                CFG_APP_USER_THRESHOLD: boost_threshold  = value[UID_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        function void apply_command(logic [CMD_W-1:0] cmd, logic [TASK_W-1:0] tid,
                                    logic [UID_W-1:0] uid);
            int          pos;
            int unsigned w;
            int          full;
            result_t     st;
            st  = '0;
            pos = -1;
            foreach (run_order[i])
                if (pos < 0 && run_order[i] == tid) pos = i;
            case (cmd)
                CMD_ENQUEUE: begin
                    if (pos < 0 && run_order.size() < DEF_MAX_TASKS) begin
                        run_order.push_back(32'(tid));
                        weight_total = weight_total + weight[tid];
                        if (weight_total > WSUM_MAX) weight_total = 32'(WSUM_MAX);
                    end
                end
                CMD_DEQUEUE: begin
                    if (pos >= 0) begin
                        weight_total = (weight_total > weight[tid]) ?
                                       weight_total - weight[tid] : 0;
                        run_order.delete(pos);
                    end
                end
                CMD_TICK: begin
                    // an unset weight becomes the default without touching the sum
                    if (weight[tid] == 0) weight[tid] = 32'(BASE_WEIGHT);
                    w = weight[tid];
                    slice_left[tid] = slice_left[tid] - 1;
                    full = int'(w * 32'(ticks_per_weight));
                    if (!(slice_left[tid] > 0 && slice_left[tid] <= full)) begin
                        if (w > BASE_WEIGHT) begin
                            w = w - 1;
                            weight[tid] = w;
                            weight_total = (weight_total > 1) ? weight_total - 1 : 0;
                        end
                        slice_left[tid] = int'(w * 32'(ticks_per_weight));
                        if (pos >= 0 && run_order.size() > 1) begin
                            run_order.delete(pos);
                            run_order.push_back(32'(tid));
                            st.resched = 1'b1;
                        end
                    end
                end
                CMD_YIELD: slice_left[tid] = 0;
                CMD_SET_CUR: begin
                    // weight changes here leave the running sum alone
                    w = (uid >= boost_threshold) ? 32'(boost_weight) : 32'(BASE_WEIGHT);
                    weight[tid]     = w;
                    slice_left[tid] = int'(w * 32'(ticks_per_weight));
                end
                default: ;
            endcase
            st.head_task     = (run_order.size() != 0) ? TASK_W'(run_order[0]) : '0;
            st.queue_empty   = (run_order.size() == 0);
            st.running_count = COUNT_OUT_W'(run_order.size());
            st.weight_sum    = WSUM_W'(weight_total);
            status_q.push_back(st);
        endfunction

        function void report(string field, logic [31:0] exp_v, logic [31:0] got_v);
            if (n_errors < MAX_REPORTS)
                $error("%s: expected %0d, got %0d", field, exp_v, got_v);
            n_errors++;
        endfunction

        function void check_status(logic [OUT_TDATA_W-1:0] tdata);
            result_t got;
            result_t exp;
            got = tdata[$bits(result_t)-1:0];
            if (status_q.size() == 0) begin
                if (n_errors < MAX_REPORTS)
                    $error("status transfer with nothing outstanding, head_task %0d",
                           got.head_task);
                n_errors++;
                return;
            end
            exp = status_q.pop_front();
            if (got.head_task !== exp.head_task)
                report("head_task", 32'(exp.head_task), 32'(got.head_task));
            if (got.queue_empty !== exp.queue_empty)
                report("queue_empty", 32'(exp.queue_empty), 32'(got.queue_empty));
            if (got.resched !== exp.resched)
                report("resched", 32'(exp.resched), 32'(got.resched));
            if (got.running_count !== exp.running_count)
                report("running_count", 32'(exp.running_count), 32'(got.running_count));
            if (got.weight_sum !== exp.weight_sum)
                report("weight_sum", 32'(exp.weight_sum), 32'(got.weight_sum));
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    run_queue_tracker tracker = new();

    bit tx_free     = 1'b0;
    bit rx_free     = 1'b0;
    int burst_left  = 4;
    int rx_hold     = 0;

    weighted_round_robin_run_queue dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // receiver: check each transfer, then alternate ready and stall stretches
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_status(m_tdata);
        if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
        end else if (rx_free || !m_tready) begin
            m_tready <= 1'b1;
            rx_hold = $urandom_range(0, 23);
        end else begin
            m_tready <= 1'b0;
            rx_hold = $urandom_range(0, 9);
        end
    end

    task automatic issue(logic [CMD_W-1:0] cmd, logic [TASK_W-1:0] tid,
                         logic [UID_W-1:0] uid);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-CMD_W-TASK_W-UID_W){1'b0}}, uid, tid, cmd};
        do @(posedge aclk); while (!s_tready);
        tracker.apply_command(cmd, tid, uid);
        if (!tx_free) begin
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                burst_left = $urandom_range(1, 20);
            end
        end
    endtask

    // wait until every status word is back; the block is then idle
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_config(logic [WEIGHT_W-1:0] boost, logic [TICKS_W-1:0] ticks,
                                logic [UID_W-1:0] thresh);
        cfg_reg_t                idx;
        logic [CFG_DATA_W-1:0]   value;
        for (int k = 0; k < 3; k++) begin
            case (k)
                0: begin idx = CFG_BOOST_WT;           value = CFG_DATA_W'(boost);  end
                1: begin idx = CFG_SLICE_TICKS;        value = CFG_DATA_W'(ticks);  end
                default: begin idx = CFG_APP_USER_THRESHOLD; value = thresh; end
            endcase
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= value;
            @(posedge aclk);
            tracker.set_reg(idx, value);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [UID_W-1:0] pick_uid();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return tracker.boost_threshold + $urandom_range(0, 2) - 1;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // percentages for enqueue, dequeue, tick and yield; the rest is set current
    // plus a few unused codes
    task automatic run_random(int n_items, int id_span, int p_enq, int p_deq,
                              int p_tick, int p_yield);
        int               r;
        logic [CMD_W-1:0] cmd;
        tx_free = ($urandom_range(0, 3) == 0);
        rx_free = ($urandom_range(0, 3) == 0);
        for (int n = 0; n < n_items; n++) begin
            r = $urandom_range(0, 99);
            if (r < p_enq)                             cmd = CMD_ENQUEUE;
            else if (r < p_enq + p_deq)                cmd = CMD_DEQUEUE;
            else if (r < p_enq + p_deq + p_tick)       cmd = CMD_TICK;
            else if (r < p_enq + p_deq + p_tick + p_yield) cmd = CMD_YIELD;
            else if (r < 96)                           cmd = CMD_SET_CUR;
            else cmd = CMD_W'($urandom_range(CMD_SET_CUR + 1, CMD_CODE_MAX));
            issue(cmd, TASK_W'($urandom_range(0, id_span - 1)), pick_uid());
            if (n % 60 == 59) begin
                tx_free = ($urandom_range(0, 3) == 0);
                rx_free = ($urandom_range(0, 3) == 0);
            end
        end
        settle();
    endtask

    initial begin
        #LIMIT_NS;
        $display("** weighted_round_robin_run_queue: FAILED **");
        $finish;
    end

    initial begin
        int span;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: default settings (boost 10, 10 ticks, threshold 10000)
        issue(CMD_TICK, 63, '0);                // never-set weight, not queued
        issue(CMD_ENQUEUE, 63, '0);
        issue(CMD_ENQUEUE, 63, '1);             // already queued
        issue(CMD_YIELD, 63, '0);
        issue(CMD_TICK, 63, '0);                // expires, sole task: no rotation
        issue(CMD_DEQUEUE, 0, '0);              // not queued
        issue(CMD_SET_CUR, 0, RST_USER_THRESHOLD);
        issue(CMD_SET_CUR, 1, RST_USER_THRESHOLD - 1);
        issue(CMD_ENQUEUE, 0, '0);
        issue(CMD_ENQUEUE, 1, '0);
        issue(CMD_SET_CUR, 63, '1);             // boosted while queued
        issue(CMD_YIELD, 0, '0);
        issue(CMD_TICK, 0, '0);                 // decay and rotate
        issue(CMD_TICK, 1, '0);
        issue(CMD_TICK, 63, '0);
        for (int c = CMD_SET_CUR + 1; c <= CMD_CODE_MAX; c++)
            issue(CMD_W'(c), 1, $urandom);
        issue(CMD_SET_CUR, 2, '0);
        issue(CMD_TICK, 2, '0);
        issue(CMD_DEQUEUE, 1, '0);              // from the middle
        issue(CMD_DEQUEUE, 63, '0);             // weight grew while queued
        issue(CMD_DEQUEUE, 0, '0);
        issue(CMD_DEQUEUE, 0, '0);
        settle();

        run_random(150, DEF_MAX_TASKS, 50, 5, 25, 8);

        write_config(8'd255, 10'd1, '0);
        run_random(250, 8, 20, 15, 40, 10);

        write_config(8'd1, 10'd1023, '1);
        run_random(200, 16, 20, 15, 25, 25);

        write_config(8'd255, 10'd3, RST_USER_THRESHOLD);
        run_random(250, DEF_MAX_TASKS, 40, 10, 30, 8);

        for (int k = 0; k < 3; k++) begin
            span = (k == 0) ? DEF_MAX_TASKS : ((k == 1) ? 8 : 16);
            write_config(WEIGHT_W'($urandom_range(1, 255)),
                         ($urandom_range(0, 1) != 0) ? TICKS_W'($urandom_range(1, 6))
                                                      : TICKS_W'($urandom_range(1, 1023)),
                         $urandom);
            case (k)
                0:       run_random(230, span, 15, 40, 30, 7);
                1:       run_random(230, span, 25, 15, 35, 12);
                default: run_random(230, span, 30, 20, 25, 12);
            endcase
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.n_errors == 0 && tracker.pending() == 0) begin
            $display("** weighted_round_robin_run_queue: PASSED **");
        end else begin
            $display("** weighted_round_robin_run_queue: FAILED **");
        end
        $finish;
    end

endmodule
